// ===== hdl/rns_pkg.sv =====
package rns_pkg;

    // Default sizes of the weight table
    localparam int MAX_NEIGHBORS_DEF = 16;
    localparam int WEIGHT_BITS_DEF   = 16;

    // Fixed field widths
    localparam int FRAC_W  = 16;
    localparam int MASK_W  = 16;
    localparam int OIDX_W  = 4;
    localparam int COUNT_W = 5;

    // Command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    // Register index of neighbor_count
    localparam logic [1:0] REG_NEIGHBOR_COUNT = 2'd0;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUM  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_SCAN = 4'b1000
    } t_state;

endpackage

// ===== hdl/roulette_neighbor_select_top.sv =====
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-----------------------------------------
// item in   | input     | start high, busy low   | i_cmd, i_weight_index, i_weight_value,
//           |           |                        | i_excluded_mask, i_random_fraction
// result    | output    | o_valid, one cycle     | o_chosen_index, o_stay
// config    | input     | APB write, pready high | neighbor_count at byte address 0
//
// A load item leaves busy low, so the next item may follow at once.
// A select item makes two passes over the weight memory, one entry read per cycle:
// a sum pass, a step to scale the draw, then a scan pass that stops at the first
// hit; the single memory read port sets this pace.
// Reset is synchronous and active low; the weight valid bits clear at once, so no
// clearing pass is needed. The result strobe is never held off.
module roulette_neighbor_select_top
    import rns_pkg::*;
#(
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
    parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item channel
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cmd,
    input  logic [3:0]           i_weight_index,
    input  logic [15:0]          i_weight_value,
    input  logic [MASK_W-1:0]    i_excluded_mask,
    input  logic [FRAC_W-1:0]    i_random_fraction,
    // result channel
    output logic                 o_valid,
    output logic [OIDX_W-1:0]    o_chosen_index,
    output logic                 o_stay,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int IDX_W   = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CNT_W   = $clog2(MAX_NEIGHBORS + 1);
    localparam int SUM_W   = WEIGHT_BITS + $clog2(MAX_NEIGHBORS + 1);
    localparam int SCALE_W = SUM_W + FRAC_W;

    // Weight memory and its valid bits
    logic [WEIGHT_BITS-1:0]   r_mem [MAX_NEIGHBORS];
    logic [MAX_NEIGHBORS-1:0] r_wvld;
    logic [WEIGHT_BITS-1:0]   r_rd_data;
    logic                     r_rd_hit;

    // Sequencer state
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_addr, n_addr;
    logic                r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx;
    logic [SUM_W-1:0]    r_total, n_total;
    logic [SUM_W-1:0]    r_run, n_run;
    logic [SCALE_W-1:0]  r_scaled, n_scaled;
    logic [MASK_W-1:0]   r_mask, n_mask;
    logic [FRAC_W-1:0]   r_frac, n_frac;
    logic [CNT_W-1:0]    r_n, n_n;
    logic [COUNT_W-1:0]  r_count;
    logic                r_out_vld, n_out_vld;
    logic [OIDX_W-1:0]   r_out_idx, n_out_idx;
    logic                r_out_stay, n_out_stay;

    logic                   w_accept;
    logic                   w_wr_en;
    logic [7:0]             w_load_idx;
    logic [IDX_W-1:0]       w_rd_addr;
    logic                   w_issue;
    logic                   w_pass_end;
    logic [WEIGHT_BITS-1:0] w_word;
    logic [7:0]             w_rd_idx8;
    logic                   w_avail;
    logic [SUM_W-1:0]       w_run_sum;
    logic                   w_hit;
    logic [7:0]             w_cnt8;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_NEIGHBOR_COUNT) ? 32'(r_count) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (psel && penable && pwrite && pready && paddr == REG_NEIGHBOR_COUNT) begin
            r_count <= pwdata[COUNT_W-1:0];
        end
    end

    // Load write: drop indexes beyond the table
    assign w_load_idx = 8'(i_weight_index);
    assign w_wr_en    = w_accept && (i_cmd == CMD_LOAD) && (w_load_idx < 8'(MAX_NEIGHBORS));

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_load_idx[IDX_W-1:0]] <= WEIGHT_BITS'(i_weight_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld <= '0;
        end else if (w_wr_en) begin
            r_wvld[w_load_idx[IDX_W-1:0]] <= 1'b1;
        end
    end

    // Memory read, registered
    assign w_issue   = (r_state == ST_SUM || r_state == ST_SCAN) && (r_addr < r_n);
    assign w_rd_addr = r_addr[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_rd_hit  <= r_wvld[w_rd_addr];
            r_rd_idx  <= w_rd_addr;
        end
    end

    // Returned entry: unwritten entries read as zero, mask covers the first sixteen
    assign w_word     = r_rd_hit ? r_rd_data : '0;
    assign w_rd_idx8  = 8'(r_rd_idx);
    assign w_avail    = (w_rd_idx8 >= 8'(MASK_W)) || !r_mask[w_rd_idx8[3:0]];
    assign w_run_sum  = r_run + SUM_W'(w_word);
    assign w_hit      = r_scaled < (SCALE_W'(w_run_sum) << FRAC_W);
    assign w_pass_end = (r_addr == r_n) && !r_rd_vld;
    assign w_cnt8     = 8'(r_count);

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_total    = r_total;
        n_run      = r_run;
        n_scaled   = r_scaled;
        n_mask     = r_mask;
        n_frac     = r_frac;
        n_n        = r_n;
        n_out_vld  = 1'b0;
        n_out_idx  = r_out_idx;
        n_out_stay = r_out_stay;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_cmd == CMD_SELECT) begin
                    n_state = ST_SUM;
                    n_addr  = '0;
                    n_total = '0;
                    n_mask  = i_excluded_mask;
                    n_frac  = i_random_fraction;
                    n_n     = (w_cnt8 > 8'(MAX_NEIGHBORS)) ? CNT_W'(MAX_NEIGHBORS)
                                                           : CNT_W'(w_cnt8);
                end
            end
            ST_SUM: begin
                if (w_issue) begin
                    n_addr = r_addr + 1'b1;
                end
                if (r_rd_vld && w_avail) begin
                    n_total = r_total + SUM_W'(w_word);
                end
                if (w_pass_end) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_scaled = SCALE_W'(r_frac) * SCALE_W'(r_total);
                if (r_total == '0) begin
                    n_state    = ST_IDLE;
                    n_out_vld  = 1'b1;
                    n_out_idx  = '0;
                    n_out_stay = 1'b1;
                end else begin
                    n_state = ST_SCAN;
                    n_addr  = '0;
                    n_run   = '0;
                end
            end
            ST_SCAN: begin
                if (w_issue) begin
                    n_addr = r_addr + 1'b1;
                end
                if (r_rd_vld && w_avail) begin
                    n_run = w_run_sum;
                    if (w_hit) begin
                        n_state    = ST_IDLE;
                        n_out_vld  = 1'b1;
                        n_out_idx  = OIDX_W'(r_rd_idx);
                        n_out_stay = 1'b0;
                    end
                end
                if (w_pass_end) begin
                    // scan ran out: report stay
                    n_state    = ST_IDLE;
                    n_out_vld  = 1'b1;
                    n_out_idx  = '0;
                    n_out_stay = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // drop in-flight reads when the pass changes
        n_rd_vld = w_issue && (n_state == r_state);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_addr    <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
            r_addr    <= n_addr;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_total    <= n_total;
        r_run      <= n_run;
        r_scaled   <= n_scaled;
        r_mask     <= n_mask;
        r_frac     <= n_frac;
        r_n        <= n_n;
        r_out_idx  <= n_out_idx;
        r_out_stay <= n_out_stay;
    end

    assign o_valid        = r_out_vld;
    assign o_chosen_index = r_out_idx;
    assign o_stay         = r_out_stay;

endmodule

// ===== hdl/rns_checker.sv =====
module rns_checker
    import rns_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_cmd,
    input logic               o_valid,
    input logic [OIDX_W-1:0]  o_chosen_index,
    input logic               o_stay
);

    // A result only closes a select that was in progress
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a select in progress");

    // Stay always comes with index zero
    a_stay_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stay |-> o_chosen_index == '0)
        else $error("stay with nonzero index");

    // A load item leaves the block free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd == CMD_LOAD |=> !busy)
        else $error("load item made the block busy");

    // A select item occupies the block
    a_select_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd == CMD_SELECT |=> busy && !o_valid)
        else $error("select item not taken up");

    // Results never come back to back
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("repeated result strobe");

endmodule

bind roulette_neighbor_select_top rns_checker u_rns_checker (.*);
